// ----- src/wrvm_pkg.sv -----
// ----------------------------------------------------------------------------
// wrvm_pkg
// Shared widths, register indexes and controller/datapath interface types of
// the windowed RMS voltage meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrvm_pkg;

    // Field and register widths
    localparam int GAIN_W     = 32;
    localparam int WIN_W      = 16;
    localparam int CNT_W      = WIN_W + 1;   // count + 1, holds 65536
    localparam int SUM_W      = 40;
    localparam int INST_W     = 29;
    localparam int RMS_W      = 28;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int FRAC_W     = 16;          // Q16 gain fraction
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int REM_W      = CNT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Iteration counts of the shared divide and square root steps
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int ITER_W     = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd65536;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd1024;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_MAG_GAIN,
        MUL_MAG_MAG,
        MUL_ROOT_GAIN
    } mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     ld_in;
        logic     ld_prod;
        mul_sel_t mul_sel;
        logic     ld_inst;
        logic     acc;
        logic     div_step;
        logic     sqrt_step;
        logic     ld_rms;
        logic     ld_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic win_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/wrvm_dp.sv -----
// ----------------------------------------------------------------------------
// wrvm_dp
// Datapath: configuration registers, offset correction, shared multiplier,
// square accumulator, restoring divider, bit-pair square root and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrvm_dp #(
    parameter int ADC_BITS = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire [wrvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [wrvm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire [ADC_BITS-1:0]                   s_sample_code,
    input  wire wrvm_pkg::dp_cmd_t               cmd,
    output wrvm_pkg::dp_status_t                 status,
    output logic signed [wrvm_pkg::INST_W-1:0]   m_instant_value,
    output logic [wrvm_pkg::RMS_W-1:0]           m_rms_value,
    output logic                                 m_rms_valid
);

    localparam int SUM_W  = wrvm_pkg::SUM_W;
    localparam int CNT_W  = wrvm_pkg::CNT_W;
    localparam int WIN_W  = wrvm_pkg::WIN_W;
    localparam int INST_W = wrvm_pkg::INST_W;
    localparam int RMS_W  = wrvm_pkg::RMS_W;
    localparam int PROD_W = wrvm_pkg::PROD_W;
    localparam int FRAC_W = wrvm_pkg::FRAC_W;
    localparam int MUL_W  = wrvm_pkg::MUL_W;
    localparam int REM_W  = wrvm_pkg::REM_W;
    localparam int QN_W   = PROD_W + 1 - FRAC_W;
    localparam int QP_W   = PROD_W - FRAC_W;
    localparam int SQ_W   = 2 * ADC_BITS;

    localparam logic [ADC_BITS-1:0] OFFSET_RESET = {1'b1, {(ADC_BITS-1){1'b0}}};
    localparam logic [INST_W-1:0]   INST_MIN     = {1'b1, {(INST_W-1){1'b0}}};
    localparam logic [INST_W-1:0]   INST_MAX     = {1'b0, {(INST_W-1){1'b1}}};
    localparam logic [RMS_W-1:0]    RMS_MAX      = {RMS_W{1'b1}};
    localparam logic [SUM_W-1:0]    BIT_INIT     = SUM_W'(1) << (SUM_W - 2);

    // Configuration
    logic [ADC_BITS-1:0]         offset_reg;
    logic [wrvm_pkg::GAIN_W-1:0] gain_reg;
    logic [WIN_W-1:0]            window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            gain_reg   <= wrvm_pkg::GAIN_RESET;
            window_reg <= wrvm_pkg::WINDOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wrvm_pkg::CFG_OFFSET: offset_reg <= cfg_wdata[ADC_BITS-1:0];
                wrvm_pkg::CFG_GAIN:   gain_reg   <= cfg_wdata[wrvm_pkg::GAIN_W-1:0];
                wrvm_pkg::CFG_WINDOW: window_reg <= cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Offset correction into sign and magnitude
    logic                neg_reg;
    logic [ADC_BITS-1:0] mag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            neg_reg <= s_sample_code < offset_reg;
            mag_reg <= (s_sample_code < offset_reg) ? offset_reg - s_sample_code
                                                    : s_sample_code - offset_reg;
        end
    end

    // Shared multiplier with registered product
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  res_reg;

    always_comb begin
        case (cmd.mul_sel)
            wrvm_pkg::MUL_MAG_GAIN: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = gain_reg;
            end
            wrvm_pkg::MUL_MAG_MAG: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            wrvm_pkg::MUL_ROOT_GAIN: begin
                mul_a = MUL_W'(res_reg[wrvm_pkg::ROOT_W-1:0]);
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_prod) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // Instantaneous value: floor of the signed Q16 product, saturated
    logic [PROD_W:0]     round_up;
    logic [QN_W-1:0]     q_neg;
    logic [QP_W-1:0]     q_pos;
    logic [INST_W-1:0]   inst_val;
    logic signed [INST_W-1:0] inst_reg;

    assign round_up = {1'b0, prod_reg} + (PROD_W + 1)'(16'hFFFF);
    assign q_neg    = round_up[PROD_W:FRAC_W];
    assign q_pos    = prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        if (neg_reg) begin
            if (q_neg > QN_W'(INST_MIN)) begin
                inst_val = INST_MIN;
            end else begin
                inst_val = ~q_neg[INST_W-1:0] + INST_W'(1);
            end
        end else begin
            if (q_pos > QP_W'(INST_MAX)) begin
                inst_val = INST_MAX;
            end else begin
                inst_val = q_pos[INST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_inst) begin
            inst_reg <= inst_val;
        end
    end

    // Square accumulator and window count
    logic [SUM_W-1:0] sum_reg;
    logic [WIN_W-1:0] count_reg;
    logic             flag_reg;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0] cnt_next;
    logic [WIN_W-1:0] win_eff;
    logic             win_done;

    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg[SQ_W-1:0]);
    assign sum_new  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_next = {1'b0, count_reg} + CNT_W'(1);
    assign win_eff  = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign win_done = cnt_next[CNT_W-1] || (cnt_next[WIN_W-1:0] >= win_eff);
    assign status.win_done = win_done;

    // Divider (restoring, one quotient bit a step) and square root share
    // num_reg: dividend/quotient first, then the square root remainder
    logic [SUM_W-1:0] num_reg;
    logic [CNT_W-1:0] den_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SUM_W-1:0] bit_reg;
    logic [REM_W-1:0] rem_sh;
    logic             div_ge;
    logic [SUM_W:0]   trial;
    logic             sq_take;

    assign rem_sh  = {rem_reg[REM_W-2:0], num_reg[SUM_W-1]};
    assign div_ge  = rem_sh >= REM_W'(den_reg);
    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_take = {1'b0, num_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end else if (cmd.acc) begin
            flag_reg <= win_done;
            if (win_done) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end else begin
                sum_reg   <= sum_new;
                count_reg <= cnt_next[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            num_reg <= sum_new;
            den_reg <= cnt_next;
            rem_reg <= '0;
            res_reg <= '0;
            bit_reg <= BIT_INIT;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? rem_sh - REM_W'(den_reg) : rem_sh;
            num_reg <= {num_reg[SUM_W-2:0], div_ge};
        end else if (cmd.sqrt_step) begin
            if (sq_take) begin
                num_reg <= num_reg - trial[SUM_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Scaled RMS, saturated
    logic [RMS_W-1:0] last_rms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_rms_reg <= '0;
        end else if (cmd.ld_rms) begin
            last_rms_reg <= (q_pos > QP_W'(RMS_MAX)) ? RMS_MAX : q_pos[RMS_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_instant_value <= inst_reg;
            m_rms_value     <= last_rms_reg;
            m_rms_valid     <= flag_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/wrvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrvm_ctrl
// Controller: sequences one sample through the datapath, runs the divide and
// square root iterations at a window end and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wrvm_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  wire wrvm_pkg::dp_status_t status,
    output wrvm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_INST,
        S_MUL_SQ,
        S_ACC,
        S_DIV,
        S_SQRT,
        S_MUL_RMS,
        S_RMS,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [wrvm_pkg::ITER_W-1:0] iter_reg;
    logic                        m_valid_reg;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // Command decode
    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = wrvm_pkg::MUL_MAG_GAIN;
        unique case (state_reg)
            S_IDLE:     cmd.ld_in = s_valid;
            S_MUL_INST: cmd.ld_prod = 1'b1;
            S_MUL_SQ: begin
                cmd.ld_prod = 1'b1;
                cmd.mul_sel = wrvm_pkg::MUL_MAG_MAG;
                cmd.ld_inst = 1'b1;
            end
            S_ACC:      cmd.acc = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_SQRT:     cmd.sqrt_step = 1'b1;
            S_MUL_RMS: begin
                cmd.ld_prod = 1'b1;
                cmd.mul_sel = wrvm_pkg::MUL_ROOT_GAIN;
            end
            S_RMS:      cmd.ld_rms = 1'b1;
            S_OUT:      cmd.ld_out = out_free;
            default: ;
        endcase
    end

    // State, iteration count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_MUL_INST;
                    end
                end
                S_MUL_INST: state_reg <= S_MUL_SQ;
                S_MUL_SQ:   state_reg <= S_ACC;
                S_ACC: begin
                    iter_reg  <= '0;
                    state_reg <= status.win_done ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (iter_reg == wrvm_pkg::ITER_W'(wrvm_pkg::DIV_STEPS - 1)) begin
                        iter_reg  <= '0;
                        state_reg <= S_SQRT;
                    end else begin
                        iter_reg <= iter_reg + wrvm_pkg::ITER_W'(1);
                    end
                end
                S_SQRT: begin
                    if (iter_reg == wrvm_pkg::ITER_W'(wrvm_pkg::SQRT_STEPS - 1)) begin
                        iter_reg  <= '0;
                        state_reg <= S_MUL_RMS;
                    end else begin
                        iter_reg <= iter_reg + wrvm_pkg::ITER_W'(1);
                    end
                end
                S_MUL_RMS:  state_reg <= S_RMS;
                S_RMS:      state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (iter_reg < wrvm_pkg::ITER_W'(wrvm_pkg::DIV_STEPS)))
        else $error("divide iteration count out of range");

    a_sqrt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> (iter_reg < wrvm_pkg::ITER_W'(wrvm_pkg::SQRT_STEPS)))
        else $error("square root iteration count out of range");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample taken while one is in work");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after output load");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.ld_out)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- src/windowed_rms_voltage_meter_core.sv -----
// ----------------------------------------------------------------------------
// windowed_rms_voltage_meter_core
// Windowed true-RMS meter: per ADC sample, an offset-corrected Q16-scaled
// instantaneous value; per window, the scaled root mean square.
//
// Usage:
//   s_* channel: one ADC code per transaction (s_valid/s_ready).
//   m_* channel: one result per sample: instant value, latest RMS value and
//     rms_valid, set on the sample that closes a window.
//   cfg_* channel: register writes (0 offset, 1 gain Q16.16, 2 window
//     length); cfg_ready is always high. Write only while the block is idle.
//   Sequence: S_MUL_INST, S_MUL_SQ, S_ACC, S_OUT; a sample that closes a
//     window adds 40 divide steps and 20 square root steps on the shared
//     iteration counter, then S_MUL_RMS and S_RMS. One sample is in work at
//     a time: the next is taken once the last is in the output register.
//   A finished result waits in the output register while the next sample is
//     already taken; a stalled receiver holds back the next result and input.
//   Reset restores the register defaults and clears the sum, count, last RMS
//     value and any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_voltage_meter_core #(
    parameter int ADC_BITS = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Configuration
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [wrvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [wrvm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Sample input
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire [ADC_BITS-1:0]                   s_sample_code,
    // Result output
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [wrvm_pkg::INST_W-1:0]   m_instant_value,
    output logic [wrvm_pkg::RMS_W-1:0]           m_rms_value,
    output logic                                 m_rms_valid
);

    wrvm_pkg::dp_cmd_t    cmd;
    wrvm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer
    wrvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage
    wrvm_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_sample_code   (s_sample_code),
        .cmd             (cmd),
        .status          (status),
        .m_instant_value (m_instant_value),
        .m_rms_value     (m_rms_value),
        .m_rms_valid     (m_rms_valid)
    );

endmodule

`default_nettype wire

// ----- tb/sv/windowed_rms_voltage_meter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_voltage_meter_core_tb
// Self-checking bench for the windowed RMS meter. A scoreboard class keeps
// its own copy of the offset, gain and window registers and of the running
// square sum. It predicts each reading: the instant value for every sample,
// and the RMS value at each window end. The bench runs directed corner
// cases, then random register settings with bursty samples and a stalling
// receiver.
// ----------------------------------------------------------------------------

localparam int CODE_W = 12;

// One expected reading of the meter
typedef struct packed {
    logic [wrvm_pkg::INST_W-1:0] instant;
    logic [wrvm_pkg::RMS_W-1:0]  rms;
    logic                        rms_flag;
} meter_reading_t;

class meter_reading_scoreboard;
    // Register copies
    logic [CODE_W-1:0]             offset_code;
    logic [wrvm_pkg::GAIN_W-1:0]   gain_q16;
    logic [wrvm_pkg::WIN_W-1:0]    window_length;
    // Window state
    logic [wrvm_pkg::SUM_W-1:0]    square_sum;
    logic [wrvm_pkg::WIN_W-1:0]    sample_count;
    logic [wrvm_pkg::RMS_W-1:0]    last_rms;

    meter_reading_t expected_readings[$];
    int unsigned    mismatches;
    int unsigned    readings_seen;

    function new();
        offset_code   = 12'd2048;
        gain_q16      = wrvm_pkg::GAIN_RESET;
        window_length = wrvm_pkg::WINDOW_RESET;
        square_sum    = '0;
        sample_count  = '0;
        last_rms      = '0;
        mismatches    = 0;
        readings_seen = 0;
    endfunction

    // Register write; unknown indexes are dropped, wide data is masked
    function void write_reg(logic [wrvm_pkg::CFG_IDX_W-1:0] idx,
                            logic [wrvm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wrvm_pkg::CFG_OFFSET: offset_code   = data[CODE_W-1:0];
            wrvm_pkg::CFG_GAIN:   gain_q16      = data;
            wrvm_pkg::CFG_WINDOW: window_length = data[wrvm_pkg::WIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Floor square root, one result bit per pass from the top
    function logic [19:0] floor_sqrt(logic [39:0] v);
        logic [19:0] root;
        logic [19:0] trial;
        int          i;
        root = '0;
        for (i = 19; i >= 0; i--) begin
            trial = root | (20'd1 << i);
            if ({20'd0, trial} * {20'd0, trial} <= v)
                root = trial;
        end
        return root;
    endfunction

    // Accepted sample: update the window and queue the expected reading
    function void take_sample(logic [CODE_W-1:0] code);
        logic                         neg;
        logic [CODE_W-1:0]            mag;
        logic [63:0]                  prod;
        logic [63:0]                  q;
        logic [63:0]                  scaled;
        logic [40:0]                  sum_next;
        logic [39:0]                  mean;
        logic [16:0]                  divisor;
        logic [wrvm_pkg::WIN_W-1:0]   win;
        meter_reading_t               r;

        neg  = code < offset_code;
        mag  = neg ? offset_code - code : code - offset_code;
        prod = 64'(mag) * 64'(gain_q16);
        r.rms_flag = 1'b0;

        // Instant value: floor of the scaled difference, saturated
        if (neg) begin
            q = (prod + 64'hFFFF) >> 16;
            r.instant = (q > 64'h1000_0000) ? 29'h1000_0000 : 29'(-q);
        end else begin
            q = prod >> 16;
            r.instant = (q > 64'h0FFF_FFFF) ? 29'h0FFF_FFFF : q[28:0];
        end

        // Saturating square sum and wrapping count
        sum_next   = 41'(square_sum) + 41'(mag) * 41'(mag);
        square_sum = sum_next[40] ? '1 : sum_next[39:0];
        sample_count = sample_count + 1'b1;

        // Window end; a zero window acts as one sample
        win = (window_length == 0) ? 16'd1 : window_length;
        if (sample_count == 0 || sample_count >= win) begin
            divisor  = (sample_count == 0) ? 17'h1_0000 : {1'b0, sample_count};
            mean     = square_sum / 40'(divisor);
            scaled   = (64'(floor_sqrt(mean)) * 64'(gain_q16)) >> 16;
            last_rms = (scaled > 64'h0FFF_FFFF) ? 28'h0FFF_FFFF : scaled[27:0];
            square_sum   = '0;
            sample_count = '0;
            r.rms_flag   = 1'b1;
        end
        r.rms = last_rms;
        expected_readings.push_back(r);
    endfunction

    // Compare one accepted reading with the oldest expectation
    function void check_reading(logic [wrvm_pkg::INST_W-1:0] instant,
                                logic [wrvm_pkg::RMS_W-1:0] rms, logic flag);
        meter_reading_t want;
        readings_seen++;
        if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: reading %0d: none expected, instant %0d rms %0d flag %0b",
                         readings_seen, $signed(instant), rms, flag);
            return;
        end
        want = expected_readings.pop_front();
        if (want.instant !== instant || want.rms !== rms || want.rms_flag !== flag) begin
            mismatches++;
            // instant/rms/flag
            if (mismatches <= 10)
                $display("ERROR: reading %0d: exp %0d/%0d/%0b got %0d/%0d/%0b",
                         readings_seen, $signed(want.instant), want.rms,
                         want.rms_flag, $signed(instant), rms, flag);
        end
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction
endclass

module windowed_rms_voltage_meter_core_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_ITEMS = 1550;

    // Index outside the register map
    localparam logic [wrvm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_RARELY
    } ready_mode_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [wrvm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [wrvm_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [CODE_W-1:0]                   s_sample_code = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [wrvm_pkg::INST_W-1:0]  m_instant_value;
    logic [wrvm_pkg::RMS_W-1:0]          m_rms_value;
    logic                                m_rms_valid;

    meter_reading_scoreboard readings = new();

    int unsigned cycle_count = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;

    windowed_rms_voltage_meter_core #(
        .ADC_BITS(CODE_W)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_code   (s_sample_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_instant_value (m_instant_value),
        .m_rms_value     (m_rms_value),
        .m_rms_valid     (m_rms_valid)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transaction, stall on a changing pattern
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            readings.check_reading(m_instant_value, m_rms_value, m_rms_valid);

        if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 200);
        end else begin
            mode_left = mode_left - 1;
        end

        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // One sample transaction; valid stays up for a following one
    task automatic send_code(input logic [CODE_W-1:0] code);
        s_valid       <= 1'b1;
        s_sample_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        readings.take_sample(code);
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [wrvm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wrvm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        readings.write_reg(idx, data);
    endtask

    // Stop sending and wait for every outstanding reading
    task automatic drain();
        s_valid <= 1'b0;
        while (readings.pending() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Codes: rail values, values around the zero offset, anything
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return CODE_W'(readings.offset_code + $urandom_range(0, 16) - 8);
            default: return CODE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // A run of samples, back to back or in bursts with random gaps
    task automatic send_run(input int count, input bit bursty);
        int burst_left;
        int i;
        burst_left = 0;
        for (i = 0; i < count; i++) begin
            if (bursty && burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end
            send_code(pick_code());
            burst_left--;
        end
    endtask

    // Random subset of register writes, with junk in the unused upper bits
    task automatic random_config();
        logic [wrvm_pkg::CFG_DATA_W-1:0] data;
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       data = 32'd0;
                1:       data = 32'd4095;
                default: data = $urandom_range(0, 4095);
            endcase
            write_reg(wrvm_pkg::CFG_OFFSET, ($urandom() & 32'hFFFF_F000) | data);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0:       data = 32'd0;
                1:       data = 32'hFFFF_FFFF;
                2, 3:    data = $urandom();
                default: data = $urandom_range(0, 32'h0004_0000);
            endcase
            write_reg(wrvm_pkg::CFG_GAIN, data);
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_UNUSED, $urandom());
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       data = 32'd0;
                1:       data = 32'd65535;
                2:       data = $urandom_range(17, 300);
                default: data = $urandom_range(1, 16);
            endcase
            write_reg(wrvm_pkg::CFG_WINDOW, ($urandom() & 32'hFFFF_0000) | data);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int n;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: rails, zero and one code below zero
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd2048);
        send_code(12'd2047);
        drain();

        // Offset zero, full gain, zero window acting as one sample
        write_reg(wrvm_pkg::CFG_OFFSET, 32'hABCD_E000);
        write_reg(wrvm_pkg::CFG_GAIN, 32'hFFFF_FFFF);
        write_reg(wrvm_pkg::CFG_WINDOW, 32'h1234_0000);
        cfg_valid <= 1'b0;
        send_code(12'd4095);
        send_code(12'd0);
        send_code(12'd4095);
        drain();

        // Offset at the top, zero gain, longest window, dropped write
        write_reg(wrvm_pkg::CFG_OFFSET, 32'h0000_0FFF);
        write_reg(wrvm_pkg::CFG_GAIN, 32'd0);
        write_reg(CFG_UNUSED, $urandom());
        write_reg(wrvm_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd1234);
        drain();

        // Window shortened below the count already taken
        write_reg(wrvm_pkg::CFG_GAIN, 32'hFFFF_FFFF);
        write_reg(wrvm_pkg::CFG_WINDOW, 32'd2);
        cfg_valid <= 1'b0;
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd100);
        drain();

        // Long receiver hold while samples keep coming
        write_reg(wrvm_pkg::CFG_OFFSET, 32'd2048);
        write_reg(wrvm_pkg::CFG_GAIN, 32'h0001_8000);
        write_reg(wrvm_pkg::CFG_WINDOW, 32'd3);
        cfg_valid <= 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (12) send_code(pick_code());
        drain();

        // Random settings and samples
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_config();
            n = $urandom_range(8, 60);
            send_run(n, $urandom_range(0, 3) != 0);
            sent += n;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (readings.mismatches == 0 && readings.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/wrvm_pkg.sv
src/wrvm_dp.sv
src/wrvm_ctrl.sv
src/windowed_rms_voltage_meter_core.sv
tb/sv/windowed_rms_voltage_meter_core_tb.sv
